>>> hdl/ucb_pkg.sv
// Shared constants for the UCB1 arm selector.
package ucb_pkg;

  localparam int DEF_MAX_ARMS = 16;

  localparam int CMD_W   = 2;
  localparam int ARM_W   = 4;
  localparam int CNT_W   = 16;
  localparam int SCORE_W = 24;
  localparam int NARM_W  = 5;
  localparam int WGT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_ARM_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_EXPLORE   = 2'd1;

  localparam logic [NARM_W-1:0] ARM_COUNT_RST = 5'd16;
  localparam logic [WGT_W-1:0]  EXPLORE_RST   = 16'd2867;

  localparam logic [15:0]        LN2_Q16   = 16'd45426;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 24'hFFFFFF;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 16'hFFFF;

endpackage

>>> hdl/ucb1_arm_selector.sv
// Top level of the UCB1 arm selector: count memory, sequencer and score datapath.
// A load writes in idle; a record reads, modifies and writes back the count memory.
// A select scans for an untried arm, then finds log2 and ln of the total, then for each
// of the n usable arms runs the two dividers and the square root and compares the score.
// One request is worked on at a time; a result waits in the output register.
// Reset clears per-entry valid bits at once, so all counts read as zero; no clearing pass.
module ucb1_arm_selector #(
  parameter int MAX_ARMS = ucb_pkg::DEF_MAX_ARMS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ucb_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [ucb_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ucb_pkg::CMD_W-1:0]    command_i,
  input  logic [ucb_pkg::ARM_W-1:0]    arm_i,
  input  logic [ucb_pkg::CNT_W-1:0]    win_preset_i,
  input  logic [ucb_pkg::CNT_W-1:0]    loss_preset_i,
  input  logic                         won_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ucb_pkg::ARM_W-1:0]    chosen_arm_o,
  output logic                         was_untried_o,
  output logic [ucb_pkg::SCORE_W-1:0]  best_score_o
);

  localparam int IW   = $clog2(MAX_ARMS);
  localparam int NLIM = (MAX_ARMS < 16) ? MAX_ARMS : 16;
  localparam int CW   = ucb_pkg::CNT_W;

  // The sequencer. Each state is one bit so that decoding stays shallow.
  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_REC_RD   = 15'h0002,
    S_REC_WR   = 15'h0004,
    S_SCAN_RD  = 15'h0008,
    S_SCAN_CHK = 15'h0010,
    S_NORM     = 15'h0020,
    S_LOG      = 15'h0040,
    S_LN       = 15'h0080,
    S_SC_RD    = 15'h0100,
    S_SC_DIV   = 15'h0200,
    S_SC_WAIT  = 15'h0400,
    S_SQRT     = 15'h0800,
    S_MUL      = 15'h1000,
    S_CMP      = 15'h2000,
    S_DONE     = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ucb_pkg::NARM_W-1:0] arm_count_q;
  logic [ucb_pkg::WGT_W-1:0]  weight_q;

  // Count memory: one word per arm holding {wins, losses}, read data registered.
  // Valid bits make an entry that was never written read as zero after reset.
  logic [2*CW-1:0] mem_q [MAX_ARMS];
  logic            vld_q [MAX_ARMS];
  logic [2*CW-1:0] rd_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [2*CW-1:0] mem_wd;
  logic [2*CW-1:0] rdat;
  logic [CW-1:0]   rd_win;
  logic [CW-1:0]   rd_loss;
  logic [CW:0]     rd_trials;

  // Sequencer and datapath registers.
  logic [ucb_pkg::NARM_W-1:0]  arm_q, arm_d;
  logic [ucb_pkg::ARM_W-1:0]   last_q, last_d;
  logic                        won_q, won_d;
  logic [20:0]                 total_q, total_d;
  logic [30:0]                 m_q, m_d;
  logic [4:0]                  e_q, e_d;
  logic [15:0]                 frac_q, frac_d;
  logic [3:0]                  it_q, it_d;
  logic [19:0]                 ln_q, ln_d;
  logic [35:0]                 sv_q, sv_d;
  logic [35:0]                 sres_q, sres_d;
  logic [35:0]                 sbit_q, sbit_d;
  logic [33:0]                 prod_q, prod_d;
  logic [ucb_pkg::ARM_W-1:0]   barm_q, barm_d;
  logic [ucb_pkg::SCORE_W-1:0] best_q, best_d;
  logic                        untried_q, untried_d;
  logic                        ovld_q, ovld_d;
  logic [ucb_pkg::ARM_W-1:0]   oarm_q, oarm_d;
  logic                        ountried_q, ountried_d;
  logic [ucb_pkg::SCORE_W-1:0] oscore_q, oscore_d;

  logic [ucb_pkg::NARM_W-1:0] n_use;
  logic                       last_arm;
  logic                       in_fire;
  logic                       div_start;
  logic [31:0]                ratio_quot;
  logic [35:0]                q_quot;
  logic                       ratio_busy;
  logic                       q_busy;
  logic [61:0]                sqr;
  logic [31:0]                mm;
  logic [36:0]                lnp;
  logic [36:0]                ssum;
  logic [24:0]                score_sum;
  logic [ucb_pkg::SCORE_W-1:0] score;

  // Usable arms: zero counts as one, and the memory depth and the arm field cap it.
  always_comb begin
    n_use = (arm_count_q == '0) ? ucb_pkg::NARM_W'(1) : arm_count_q;
    if (n_use > ucb_pkg::NARM_W'(NLIM)) begin
      n_use = ucb_pkg::NARM_W'(NLIM);
    end
  end

  assign last_arm   = (arm_q == n_use - 1'b1);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign rdat      = rd_vld_q ? rd_q : '0;
  assign rd_win    = rdat[2*CW-1:CW];
  assign rd_loss   = rdat[CW-1:0];
  assign rd_trials = {1'b0, rd_win} + {1'b0, rd_loss};

  // Squaring step of the fractional log2 and the ln2 scaling.
  assign sqr = {31'd0, m_q} * {31'd0, m_q};
  assign mm  = sqr[61:30];
  assign lnp = {16'd0, e_q, frac_q} * {21'd0, ucb_pkg::LN2_Q16};

  // Square root trial subtraction, two radicand bits per cycle.
  assign ssum = {1'b0, sres_q} + {1'b0, sbit_q};

  // Score: ratio plus exploration, saturated to the Q8.16 range.
  assign score_sum = {8'd0, ratio_quot[16:0]} + {3'd0, prod_q[33:12]};
  assign score     = (score_sum > {1'b0, ucb_pkg::SCORE_MAX}) ? ucb_pkg::SCORE_MAX
                                                              : score_sum[23:0];

  // Two dividers run side by side: wins/trials and ln/trials.
  ucb_div #(.NW(32), .DW(17)) u_div_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({rd_win, 16'd0}),
    .divisor_i  (rd_trials),
    .quot_o     (ratio_quot),
    .busy_o     (ratio_busy)
  );

  ucb_div #(.NW(36), .DW(17)) u_div_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({ln_q, 16'd0}),
    .divisor_i  (rd_trials),
    .quot_o     (q_quot),
    .busy_o     (q_busy)
  );

  always_comb begin
    state_d    = state_q;
    arm_d      = arm_q;
    last_d     = last_q;
    won_d      = won_q;
    total_d    = total_q;
    m_d        = m_q;
    e_d        = e_q;
    frac_d     = frac_q;
    it_d       = it_q;
    ln_d       = ln_q;
    sv_d       = sv_q;
    sres_d     = sres_q;
    sbit_d     = sbit_q;
    prod_d     = prod_q;
    barm_d     = barm_q;
    best_d     = best_q;
    untried_d  = untried_q;
    ovld_d     = ovld_q;
    oarm_d     = oarm_q;
    ountried_d = ountried_q;
    oscore_d   = oscore_q;
    rd_addr    = IW'(arm_q);
    mem_we     = 1'b0;
    mem_wa     = IW'(arm_i);
    mem_wd     = {win_preset_i, loss_preset_i};
    div_start  = 1'b0;

    // The output register empties when the consumer takes the result.
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (command_i)
            ucb_pkg::CMD_LOAD: begin
              // A load of an arm beyond the memory depth is dropped.
              mem_we = (32'(arm_i) < MAX_ARMS);
            end
            ucb_pkg::CMD_SELECT: begin
              arm_d     = '0;
              total_d   = '0;
              untried_d = 1'b0;
              state_d   = S_SCAN_RD;
            end
            ucb_pkg::CMD_RECORD: begin
              won_d   = won_i;
              state_d = S_REC_RD;
            end
            default: ;
          endcase
        end
      end
      S_REC_RD: begin
        rd_addr = IW'(last_q);
        state_d = S_REC_WR;
      end
      S_REC_WR: begin
        // Read-modify-write of the remembered arm, saturating the count.
        mem_wa = IW'(last_q);
        mem_we = (32'(last_q) < MAX_ARMS);
        mem_wd = rdat;
        if (won_q) begin
          if (rd_win != ucb_pkg::COUNT_MAX) begin
            mem_wd[2*CW-1:CW] = rd_win + 1'b1;
          end
        end else begin
          if (rd_loss != ucb_pkg::COUNT_MAX) begin
            mem_wd[CW-1:0] = rd_loss + 1'b1;
          end
        end
        state_d = S_IDLE;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_trials == '0) begin
          barm_d    = arm_q[ucb_pkg::ARM_W-1:0];
          best_d    = '0;
          untried_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          total_d = total_q + 21'(rd_trials);
          if (last_arm) begin
            m_d     = 31'(total_d);
            e_d     = 5'd30;
            state_d = S_NORM;
          end else begin
            arm_d   = arm_q + 1'b1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_NORM: begin
        // Shift the total up to Q1.30 one place a cycle to find its exponent.
        if (m_q[30]) begin
          it_d    = '0;
          frac_d  = '0;
          state_d = S_LOG;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          e_d = e_q - 1'b1;
        end
      end
      S_LOG: begin
        frac_d = {frac_q[14:0], mm[31]};
        m_d    = mm[31] ? mm[31:1] : mm[30:0];
        it_d   = it_q + 1'b1;
        if (it_q == 4'd15) begin
          state_d = S_LN;
        end
      end
      S_LN: begin
        ln_d    = lnp[35:16];
        arm_d   = '0;
        state_d = S_SC_RD;
      end
      S_SC_RD: begin
        state_d = S_SC_DIV;
      end
      S_SC_DIV: begin
        div_start = 1'b1;
        state_d   = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (!q_busy && !ratio_busy) begin
          sv_d    = q_quot;
          sres_d  = '0;
          sbit_d  = 36'd1 << 34;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if ({1'b0, sv_q} >= ssum) begin
          sv_d   = sv_q - ssum[35:0];
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = {18'd0, weight_q} * {16'd0, sres_q[17:0]};
        state_d = S_CMP;
      end
      S_CMP: begin
        // Strictly greater replaces, so the lowest arm keeps a tie.
        if (arm_q == '0 || score > best_q) begin
          best_d = score;
          barm_d = arm_q[ucb_pkg::ARM_W-1:0];
        end
        if (last_arm) begin
          state_d = S_DONE;
        end else begin
          arm_d   = arm_q + 1'b1;
          state_d = S_SC_RD;
        end
      end
      S_DONE: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d     = 1'b1;
          oarm_d     = barm_q;
          ountried_d = untried_q;
          oscore_d   = best_q;
          last_d     = barm_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Count memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q     <= mem_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ARMS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (mem_we) begin
      vld_q[mem_wa] <= 1'b1;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      arm_q       <= '0;
      last_q      <= '0;
      it_q        <= '0;
      ovld_q      <= 1'b0;
      arm_count_q <= ucb_pkg::ARM_COUNT_RST;
      weight_q    <= ucb_pkg::EXPLORE_RST;
    end else begin
      state_q <= state_d;
      arm_q   <= arm_d;
      last_q  <= last_d;
      it_q    <= it_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ucb_pkg::CFG_ARM_COUNT: arm_count_q <= cfg_wdata_i[ucb_pkg::NARM_W-1:0];
          ucb_pkg::CFG_EXPLORE:   weight_q    <= cfg_wdata_i[ucb_pkg::WGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    won_q      <= won_d;
    total_q    <= total_d;
    m_q        <= m_d;
    e_q        <= e_d;
    frac_q     <= frac_d;
    ln_q       <= ln_d;
    sv_q       <= sv_d;
    sres_q     <= sres_d;
    sbit_q     <= sbit_d;
    prod_q     <= prod_d;
    barm_q     <= barm_d;
    best_q     <= best_d;
    untried_q  <= untried_d;
    oarm_q     <= oarm_d;
    ountried_q <= ountried_d;
    oscore_q   <= oscore_d;
  end

  assign out_valid_o   = ovld_q;
  assign chosen_arm_o  = oarm_q;
  assign was_untried_o = ountried_q;
  assign best_score_o  = oscore_q;

`ifndef SYNTHESIS
  a_untried_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_untried_o |-> best_score_o == '0)
    else $error("untried result carries a nonzero score");

  a_chosen_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, chosen_arm_o} < n_use)
    else $error("chosen arm beyond the usable arms");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && (!out_valid_o || out_ready_i) |=>
      out_valid_o && chosen_arm_o == $past(barm_q) && last_q == chosen_arm_o)
    else $error("result not registered or chosen arm not remembered");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SC_DIV |=> q_busy && ratio_busy)
    else $error("dividers not started");
`endif

endmodule

>>> hdl/ucb_div.sv
// Restoring divider producing one quotient bit per cycle.
module ucb_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quot_o,
  output logic          busy_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    sh   = {rem_q, quo_q[NW-1]};
    ge   = (sh >= {1'b0, div_q});
    diff = sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
    end
  end

  assign quot_o = quo_q;
  assign busy_o = busy_q;

endmodule

>>> sim/tb_ucb1_arm_selector.sv
// Self-checking testbench for the UCB1 arm selector: a scoreboard predicts every selection.
`timescale 1ns / 1ps

module tb_ucb1_arm_selector;

  localparam int          ARMS       = ucb_pkg::DEF_MAX_ARMS;
  localparam int          ITEMS_EACH = 170;
  localparam longint      CYCLE_CAP  = 20000000;
  localparam int          HOLD_LEN   = 2000;

  // One request as the sender offers it.
  typedef struct packed {
    logic [ucb_pkg::CMD_W-1:0] cmd;
    logic [ucb_pkg::ARM_W-1:0] arm;
    logic [ucb_pkg::CNT_W-1:0] win;
    logic [ucb_pkg::CNT_W-1:0] loss;
    logic                      won;
  } arm_req_t;

  // One selection as the block reports it.
  typedef struct packed {
    logic [ucb_pkg::ARM_W-1:0]   arm;
    logic                        untried;
    logic [ucb_pkg::SCORE_W-1:0] score;
  } choice_t;

  // Keeps its own copy of the counts and registers, and the selections still owed.
  class arm_choice_book;
    logic [ucb_pkg::CNT_W-1:0]  wins[ARMS];
    logic [ucb_pkg::CNT_W-1:0]  losses[ARMS];
    logic [ucb_pkg::ARM_W-1:0]  last_arm;
    logic [ucb_pkg::NARM_W-1:0] arm_cnt;
    logic [ucb_pkg::WGT_W-1:0]  weight;
    choice_t                    pending_choices[$];
    int                         mismatches;

    function new();
      foreach (wins[i]) begin
        wins[i]   = '0;
        losses[i] = '0;
      end
      last_arm   = '0;
      arm_cnt    = ucb_pkg::ARM_COUNT_RST;
      weight     = ucb_pkg::EXPLORE_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [ucb_pkg::CIDX_W-1:0] idx, logic [ucb_pkg::CFG_W-1:0] val);
      if (idx == ucb_pkg::CFG_ARM_COUNT) arm_cnt = val[ucb_pkg::NARM_W-1:0];
      else if (idx == ucb_pkg::CFG_EXPLORE) weight = val[ucb_pkg::WGT_W-1:0];
    endfunction

    // log2 in Q.16: integer part from the top set bit, fraction by repeated squaring.
    function bit [63:0] log2_q16(bit [63:0] t);
      bit [63:0] m;
      bit [63:0] frac;
      int        e;
      e = 0;
      frac = 0;
      while (e < 62 && (t >> (e + 1)) != 0) e++;
      m = (e <= 30) ? (t << (30 - e)) : (t >> (e - 30));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (64'(e) << 16) | frac;
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function bit [23:0] score_of(int a, bit [63:0] ln_v);
      bit [63:0] w;
      bit [63:0] t;
      bit [63:0] sc;
      w  = 64'(wins[a]);
      t  = w + 64'(losses[a]);
      sc = ((w << 16) / t) + ((64'(weight) * root_floor((ln_v << 16) / t)) >> 12);
      if (sc > 64'(ucb_pkg::SCORE_MAX)) sc = 64'(ucb_pkg::SCORE_MAX);
      return sc[23:0];
    endfunction

    function void note_request(arm_req_t r);
      choice_t   c;
      int        n;
      bit [63:0] total;
      bit [63:0] ln_v;
      bit [23:0] s;
      bit        hit;
      case (r.cmd)
        ucb_pkg::CMD_LOAD: begin
          wins[r.arm]   = r.win;
          losses[r.arm] = r.loss;
        end
        ucb_pkg::CMD_RECORD: begin
          if (r.won) begin
            if (wins[last_arm] != ucb_pkg::COUNT_MAX) wins[last_arm]++;
          end else begin
            if (losses[last_arm] != ucb_pkg::COUNT_MAX) losses[last_arm]++;
          end
        end
        ucb_pkg::CMD_SELECT: begin
          n = (arm_cnt == 0) ? 1 : ((arm_cnt > ARMS) ? ARMS : int'(arm_cnt));
          total = 0;
          hit = 0;
          c = '0;
          for (int a = 0; a < n && !hit; a++) begin
            if (wins[a] == 0 && losses[a] == 0) begin
              hit = 1;
              c.arm = ucb_pkg::ARM_W'(a);
              c.untried = 1'b1;
            end
            total += 64'(wins[a]) + 64'(losses[a]);
          end
          if (!hit) begin
            ln_v = (log2_q16(total) * 64'(ucb_pkg::LN2_Q16)) >> 16;
            // Strictly greater only, so the lowest arm keeps a tie.
            for (int a = 0; a < n; a++) begin
              s = score_of(a, ln_v);
              if (a == 0 || s > c.score) begin
                c.score = s;
                c.arm = ucb_pkg::ARM_W'(a);
              end
            end
          end
          last_arm = c.arm;
          pending_choices = {pending_choices, c};
        end
        default: ;
      endcase
    endfunction

    function void check_choice(choice_t got);
      choice_t want;
      if (pending_choices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected selection: arm %0d untried %0d score %0h",
                   got.arm, got.untried, got.score);
        return;
      end
      want = pending_choices.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("selection mismatch: want arm %0d untried %0d score %0h, got %0d %0d %0h",
                   want.arm, want.untried, want.score, got.arm, got.untried, got.score);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [ucb_pkg::CIDX_W-1:0]  cfg_idx_i;
  logic [ucb_pkg::CFG_W-1:0]   cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [ucb_pkg::CMD_W-1:0]   command_i;
  logic [ucb_pkg::ARM_W-1:0]   arm_i;
  logic [ucb_pkg::CNT_W-1:0]   win_preset_i;
  logic [ucb_pkg::CNT_W-1:0]   loss_preset_i;
  logic                        won_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [ucb_pkg::ARM_W-1:0]   chosen_arm_o;
  logic                        was_untried_o;
  logic [ucb_pkg::SCORE_W-1:0] best_score_o;

  arm_choice_book book = new();
  longint         cycles = 0;
  bit             no_idle = 1'b0;
  bit             hold_go = 1'b0;
  bit             hold_done = 1'b0;
  int             hold_left = 0;
  int             usable = ARMS;

  ucb1_arm_selector dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .arm_i, .win_preset_i, .loss_preset_i, .won_i,
    .out_valid_o, .out_ready_i, .chosen_arm_o, .was_untried_o, .best_score_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a run that stops making progress ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver. It normally stalls at random; once asked, it holds off for a long stretch so
  // the block's output register fills and the input side backs up.
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Outputs are sampled at the rising edge, before the block's registers move.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.check_choice('{arm: chosen_arm_o, untried: was_untried_o, score: best_score_o});
  end

  // Offers one request; called and returns on a falling edge. Valid stays high when the
  // next request follows without a gap.
  task automatic send(arm_req_t r);
    if (!no_idle) begin
      while ($urandom_range(99) < 28) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    command_i     = r.cmd;
    arm_i         = r.arm;
    win_preset_i  = r.win;
    loss_preset_i = r.loss;
    won_i         = r.won;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [ucb_pkg::CMD_W-1:0] cmd, int arm, int win, int loss,
                          int won);
    send('{cmd: cmd, arm: ucb_pkg::ARM_W'(arm), win: ucb_pkg::CNT_W'(win),
           loss: ucb_pkg::CNT_W'(loss), won: 1'(won)});
  endtask

  // Waits for every owed selection, then for a record or load still in the pipe.
  task automatic drain();
    in_valid_i = 1'b0;
    while (book.pending_choices.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ucb_pkg::CIDX_W-1:0] idx, logic [ucb_pkg::CFG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    book.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic int pick_count();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(1, 20);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Mostly well-formed play: preset every usable arm, then rounds of select and record.
  // The rest is noise, including the unused command code.
  task automatic play(int goal);
    int       sent;
    arm_req_t r;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(9) < 6) begin
        for (int a = 0; a < usable; a++) begin
          send_cmd(ucb_pkg::CMD_LOAD, a, pick_count(), pick_count(), 0);
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_cmd(ucb_pkg::CMD_SELECT, $urandom_range(15), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(1));
          send_cmd(ucb_pkg::CMD_RECORD, $urandom_range(15), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(1));
          sent += 2;
        end
      end else begin
        r = arm_req_t'({$urandom, $urandom});
        send(r);
        if (r.cmd != ucb_pkg::CMD_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    int arm_table[9];
    int wgt_table[9];
    arm_table = '{1, 0, 3, 31, 4, 2, 20, 7, 16};
    wgt_table = '{0, 65535, 2867, 4096, 1, 65535, 0, 12345, 2867};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ucb_pkg::CFG_ARM_COUNT;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = ucb_pkg::CMD_LOAD;
    arm_i         = '0;
    win_preset_i  = '0;
    loss_preset_i = '0;
    won_i         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a record before any select lands on arm zero, so the first select
    // skips to arm one as the lowest untried arm.
    send_cmd(ucb_pkg::CMD_RECORD, 9, 0, 0, 1);
    send_cmd(ucb_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_cmd(ucb_pkg::CMD_LOAD, 0, 0, 0, 0);
    send_cmd(ucb_pkg::CMD_SELECT, 15, 65535, 65535, 1);
    send_cmd(ucb_pkg::CMD_UNUSED, 15, 65535, 65535, 1);
    // Every arm tried, with the extremes of the counts; arm five is already full, and the
    // records that follow the selection update the arm it chose.
    for (int a = 0; a < ARMS; a++)
      send_cmd(ucb_pkg::CMD_LOAD, a, (a == 5) ? 65535 : (a == 9 ? 0 : a * 7 + 1),
               (a == 5) ? 65535 : (a == 9 ? 65535 : a + 1), 0);
    send_cmd(ucb_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_cmd(ucb_pkg::CMD_RECORD, 0, 0, 0, 1);
    send_cmd(ucb_pkg::CMD_RECORD, 0, 0, 0, 0);
    send_cmd(ucb_pkg::CMD_SELECT, 0, 0, 0, 0);

    // Random phases under different settings; registers change only once the block is idle.
    foreach (arm_table[p]) begin
      drain();
      write_reg(ucb_pkg::CFG_ARM_COUNT, ucb_pkg::CFG_W'(arm_table[p]));
      write_reg(ucb_pkg::CFG_EXPLORE, ucb_pkg::CFG_W'(wgt_table[p]));
      usable  = (arm_table[p] == 0) ? 1 : (arm_table[p] > ARMS ? ARMS : arm_table[p]);
      no_idle = (p == 2);
      if (p == 4) hold_go = 1'b1;
      play(ITEMS_EACH);
    end

    in_valid_i = 1'b0;
    no_idle = 1'b0;
    while (book.pending_choices.size() != 0) @(negedge clk_i);
    repeat (32) @(negedge clk_i);
    if (book.mismatches == 0 && book.pending_choices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ucb_pkg.sv
hdl/ucb_div.sv
hdl/ucb1_arm_selector.sv
sim/tb_ucb1_arm_selector.sv
